### design/uer_pkg.sv
// Package for the ultrasonic echo ranger: shared types, field widths,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  // field and datapath widths
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned ROUND_W = 6;
  localparam int unsigned WSUM_W  = 22;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned PROD_W  = WSUM_W + SCALE_W;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned QUO_W   = PROD_W - FRAC_W;
  localparam int unsigned DIST_W  = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // register reset values
  localparam logic [TICK_W-1:0]  SETTLE_RST  = 16'd100;
  localparam logic [TICK_W-1:0]  PULSE_RST   = 16'd20;
  localparam logic [TICK_W-1:0]  TIMEOUT_RST = 16'd30000;
  localparam logic [TICK_W-1:0]  GAP_RST     = 16'd100;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 16'd1124;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE  = 3'd0,
    CFG_PULSE   = 3'd1,
    CFG_TIMEOUT = 3'd2,
    CFG_GAP     = 3'd3,
    CFG_SCALE   = 3'd4
  } cfg_idx_t;

  // measurement phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_PULSE  = 3'd2,
    PH_ECHO   = 3'd3,
    PH_GAP    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0]  settle_ticks;
    logic [TICK_W-1:0]  pulse_ticks;
    logic [TICK_W-1:0]  timeout_ticks;
    logic [TICK_W-1:0]  gap_ticks;
    logic [SCALE_W-1:0] scale_q16;
  } uer_cfg_t;

  // per-beat status that rides along the scaling pipeline
  typedef struct packed {
    logic trigger;
    logic done_res;
    logic timed_out;
    logic busy_res;
  } uer_flags_t;

  // beat from the sequencer to the scaling pipeline
  typedef struct packed {
    uer_flags_t         flags;
    logic [WSUM_W-1:0]  width_sum;
  } uer_res_t;

endpackage

`default_nettype wire

### design/uer_if.sv
// Valid/ready channel interfaces for the ultrasonic echo ranger.
// Depends on uer_pkg for the distance width.
`timescale 1ns / 1ps
`default_nettype none

interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink   (input valid, input start_req, input echo, output ready);
endinterface

interface uer_out_if;
  import uer_pkg::*;
  logic              valid;
  logic              ready;
  logic              trigger;
  logic              done_res;
  logic [DIST_W-1:0] distance_q8;
  logic              timed_out;
  logic              busy_res;

  modport source (output valid, output trigger, output done_res, output distance_q8,
                  output timed_out, output busy_res, input ready);
  modport sink   (input valid, input trigger, input done_res, input distance_q8,
                  input timed_out, input busy_res, output ready);
endinterface

`default_nettype wire

### design/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: register bank, sequencer and
// distance scaling pipeline. Uses uer_pkg, uer_if, uer_seq, uer_scale.
//
//   channel    dir  handshake       payload
//   in_chan    in   valid / ready   start_req, echo (one beat per time tick)
//   out_chan   out  valid / ready   trigger, done_res, distance_q8, timed_out, busy_res
//   cfg_*      in   cfg_we          cfg_index, cfg_data (write only)
//
// One beat in and one beat out per cycle while out_chan.ready stays high; each result
// passes, after its input beat, the sequencer result register, the multiply stage
// and a stage that divides by SAMPLES with a reciprocal multiply and saturates.
// Reset is synchronous: registers go to their defaults and the pipeline empties.
// With out_chan.ready low the last stage holds; empty stages before it keep
// filling and in_chan.ready drops once every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int unsigned SAMPLES = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  uer_in_if.sink                              in_chan,
  uer_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
  import uer_pkg::*;

  uer_cfg_t cfg_r;
  logic     seq_valid, seq_ready;
  uer_res_t seq_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks  <= SETTLE_RST;
      cfg_r.pulse_ticks   <= PULSE_RST;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.gap_ticks     <= GAP_RST;
      cfg_r.scale_q16     <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SETTLE:  cfg_r.settle_ticks  <= cfg_data;
        CFG_PULSE:   cfg_r.pulse_ticks   <= cfg_data;
        CFG_TIMEOUT: cfg_r.timeout_ticks <= cfg_data;
        CFG_GAP:     cfg_r.gap_ticks     <= cfg_data;
        CFG_SCALE:   cfg_r.scale_q16     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // phase sequencer
  uer_seq #(
    .SAMPLES (SAMPLES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_chan  (in_chan),
    .dn_valid (seq_valid),
    .dn_ready (seq_ready),
    .dn_data  (seq_data)
  );

  // scaling and averaging pipeline
  uer_scale #(
    .SAMPLES (SAMPLES)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale_q16 (cfg_r.scale_q16),
    .up_valid  (seq_valid),
    .up_ready  (seq_ready),
    .up_data   (seq_data),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

### design/uer_seq.sv
// Measurement sequencer: phase state machine stepped once per input beat,
// with a registered result stage toward the scaling pipeline. Uses uer_pkg, uer_in_if.
`timescale 1ns / 1ps
`default_nettype none

module uer_seq #(
  parameter int unsigned SAMPLES = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire uer_pkg::uer_cfg_t cfg,
  uer_in_if.sink                in_chan,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output uer_pkg::uer_res_t     dn_data
);
  import uer_pkg::*;

  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(SAMPLES);

  phase_t              ph_r, ph_nxt;
  logic [TICK_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [TICK_W-1:0]   ew_r, ew_nxt;
  logic                seen_r, seen_nxt;
  logic [ROUND_W-1:0]  ridx_r, ridx_nxt;
  logic [WSUM_W-1:0]   sum_r, sum_nxt;
  logic [WSUM_W:0]     sum_ext;
  logic                anyto_r, anyto_nxt;
  logic                done;
  logic                round_fin, gap_fin, settle_go;
  logic [TICK_W-1:0]   pulse_lim, to_lim;

  logic                res_vld_r;
  uer_res_t            res_r;
  logic                stage_go, in_fire;

  // result stage moves when empty or drained downstream
  assign stage_go      = !res_vld_r || dn_ready;
  assign in_chan.ready = stage_go;
  assign in_fire       = in_chan.valid && stage_go;

  assign pulse_lim = (cfg.pulse_ticks == '0) ? TICK_W'(1) : cfg.pulse_ticks;
  assign to_lim    = (cfg.timeout_ticks == '0) ? TICK_W'(1) : cfg.timeout_ticks;
  assign cnt_inc   = cnt_r + TICK_W'(1);

  // next state for one tick
  always_comb begin
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    ew_nxt    = ew_r;
    seen_nxt  = seen_r;
    ridx_nxt  = ridx_r;
    sum_nxt   = sum_r;
    sum_ext   = '0;
    anyto_nxt = anyto_r;
    done      = 1'b0;
    round_fin = 1'b0;
    gap_fin   = 1'b0;
    settle_go = 1'b0;

    case (ph_r)
      PH_SETTLE: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= cfg.settle_ticks) begin
          ph_nxt  = PH_PULSE;
          cnt_nxt = '0;
        end
      end
      PH_PULSE: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= pulse_lim) begin
          ph_nxt   = PH_ECHO;
          cnt_nxt  = '0;
          ew_nxt   = '0;
          seen_nxt = 1'b0;
        end
      end
      PH_ECHO: begin
        cnt_nxt = cnt_inc;
        if (!seen_r) begin
          if (in_chan.echo) begin
            seen_nxt = 1'b1;
            ew_nxt   = TICK_W'(1);
          end
        end else if (!in_chan.echo) begin
          round_fin = 1'b1;
        end else begin
          ew_nxt = ew_r + TICK_W'(1);
        end
        // timeout, unless the falling edge already closed the round
        if (!(seen_r && !in_chan.echo) && (cnt_inc >= to_lim)) begin
          if (!seen_nxt) begin
            ew_nxt    = '0;
            anyto_nxt = 1'b1;
          end
          round_fin = 1'b1;
        end
      end
      PH_GAP: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= cfg.gap_ticks) begin
          gap_fin = 1'b1;
        end
      end
      default: begin
        ph_nxt = PH_IDLE;
        if (in_chan.start_req) begin
          ridx_nxt  = '0;
          sum_nxt   = '0;
          anyto_nxt = 1'b0;
          ew_nxt    = '0;
          seen_nxt  = 1'b0;
          settle_go = 1'b1;
        end
      end
    endcase

    // end of round: accumulate width with saturation, then gap or straight on
    if (round_fin) begin
      sum_ext  = {1'b0, sum_r} + (WSUM_W + 1)'(ew_nxt);
      sum_nxt  = sum_ext[WSUM_W] ? '1 : sum_ext[WSUM_W-1:0];
      ridx_nxt = ridx_r + ROUND_W'(1);
      if (cfg.gap_ticks == '0) begin
        gap_fin = 1'b1;
      end else begin
        ph_nxt  = PH_GAP;
        cnt_nxt = '0;
      end
    end

    // end of gap: report after the last round, else next round
    if (gap_fin) begin
      if (ridx_nxt == LAST_ROUND) begin
        ph_nxt  = PH_IDLE;
        cnt_nxt = '0;
        done    = 1'b1;
      end else begin
        settle_go = 1'b1;
      end
    end

    // zero settle time goes straight to the pulse
    if (settle_go) begin
      ph_nxt  = (cfg.settle_ticks == '0) ? PH_PULSE : PH_SETTLE;
      cnt_nxt = '0;
    end
  end

  // sequencer state, stepped per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_IDLE;
      cnt_r   <= '0;
      ew_r    <= '0;
      seen_r  <= 1'b0;
      ridx_r  <= '0;
      sum_r   <= '0;
      anyto_r <= 1'b0;
    end else if (in_fire) begin
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      ew_r    <= ew_nxt;
      seen_r  <= seen_nxt;
      ridx_r  <= ridx_nxt;
      sum_r   <= sum_nxt;
      anyto_r <= anyto_nxt;
    end
  end

  // result stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (stage_go) begin
      res_vld_r <= in_chan.valid;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r.flags.trigger   <= (ph_r == PH_PULSE);
      res_r.flags.busy_res  <= (ph_r != PH_IDLE);
      res_r.flags.done_res  <= done;
      res_r.flags.timed_out <= done && anyto_nxt;
      res_r.width_sum       <= sum_nxt;
    end
  end

  assign dn_valid = res_vld_r;
  assign dn_data  = res_r;

endmodule

`default_nettype wire

### design/uer_scale.sv
// Distance scaling pipeline: width sum times scale, then a reciprocal multiply
// for the division by the sample count, saturation to 24 bits. Uses uer_pkg, uer_out_if.
`timescale 1ns / 1ps
`default_nettype none

module uer_scale #(
  parameter int unsigned SAMPLES = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [uer_pkg::SCALE_W-1:0] scale_q16,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire uer_pkg::uer_res_t up_data,
  uer_out_if.source              out_chan
);
  import uer_pkg::*;

  // floor(x / SAMPLES) for a QUO_W-bit x is (x * RCP_M) >> RCP_SH
  localparam int unsigned RCP_L  = $clog2(SAMPLES);
  localparam int unsigned RCP_SH = QUO_W + RCP_L;
  localparam int unsigned RCP_MW = QUO_W + 1;
  localparam int unsigned RCP_PW = QUO_W + RCP_MW;
  localparam logic [RCP_MW-1:0] RCP_M =
    RCP_MW'(((64'd1 << RCP_SH) / 64'(SAMPLES)) + 64'd1);

  // multiply stage
  logic               m_vld_r;
  uer_flags_t         m_flags_r;
  logic [QUO_W-1:0]   m_word_r;
  logic [PROD_W-1:0]  prod_full;

  // output stage
  logic               o_vld_r;
  uer_flags_t         o_flags_r;
  logic [DIST_W-1:0]  o_dist_r;
  logic [RCP_PW-1:0]  rcp_prod;
  logic [RCP_PW-1:0]  quo;
  logic [DIST_W-1:0]  dist_sat;

  logic               m_go, o_go;

  // stall chain: a stage moves when empty or when the next one moves
  assign o_go     = !o_vld_r || out_chan.ready;
  assign m_go     = !m_vld_r || o_go;
  assign up_ready = m_go;

  // width sum times cm-per-tick scale
  assign prod_full = PROD_W'(up_data.width_sum) * PROD_W'(scale_q16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (m_go) begin
      m_vld_r <= up_valid;
    end
  end

  // drop the q8 fraction bits here, division then runs on the rest
  always_ff @(posedge clk) begin
    if (m_go && up_valid) begin
      m_flags_r <= up_data.flags;
      m_word_r  <= prod_full[PROD_W-1:FRAC_W];
    end
  end

  // divide by the sample count through the reciprocal
  assign rcp_prod = RCP_PW'(m_word_r) * RCP_PW'(RCP_M);
  assign quo      = rcp_prod >> RCP_SH;

  // saturate, zero when not done
  always_comb begin
    if (!m_flags_r.done_res) begin
      dist_sat = '0;
    end else if (quo[RCP_PW-1:DIST_W] != '0) begin
      dist_sat = DIST_MAX;
    end else begin
      dist_sat = quo[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_go) begin
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_go && m_vld_r) begin
      o_flags_r <= m_flags_r;
      o_dist_r  <= dist_sat;
    end
  end

  assign out_chan.valid       = o_vld_r;
  assign out_chan.trigger     = o_flags_r.trigger;
  assign out_chan.done_res    = o_flags_r.done_res;
  assign out_chan.timed_out   = o_flags_r.timed_out;
  assign out_chan.busy_res    = o_flags_r.busy_res;
  assign out_chan.distance_q8 = o_dist_r;

endmodule

`default_nettype wire

### verif/ultrasonic_echo_ranger_test.sv
// Self-checking testbench for the ultrasonic echo ranger: directed drills, then random
// phases under sender and receiver idling, checked beat by beat against a local predictor.
// Depends on uer_pkg, uer_if and the ultrasonic_echo_ranger top level.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_test;
  import uer_pkg::*;

  localparam int unsigned SAMPLES = 10;
  localparam logic [PROD_W-1:0] AVG_DIV = PROD_W'(SAMPLES * 256);
  localparam int STALL_LIMIT = 2000;
  localparam int DRILL_N = 9;

  // one result beat: ranger status for one tick
  typedef struct packed {
    logic              trigger;
    logic              done_res;
    logic [DIST_W-1:0] distance_q8;
    logic              timed_out;
    logic              busy_res;
  } range_beat_t;

  // predictor state of the measurement sequencer
  typedef struct packed {
    phase_t             phase;
    logic [TICK_W-1:0]  count;
    logic [TICK_W-1:0]  width;
    logic               seen;
    logic [ROUND_W-1:0] rounds;
    logic [WSUM_W-1:0]  wsum;
    logic               any_to;
  } ranger_state_t;

  // directed measurement: settings, echo shape and, where obvious, the distance
  typedef struct packed {
    uer_cfg_t          cfg;
    logic [16:0]       rise;
    logic [16:0]       width;
    logic              hold_start;
    logic              typed;
    logic [DIST_W-1:0] exp_dist;
    logic              tout;
  } drill_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  uer_in_if  in_chan ();
  uer_out_if out_chan ();

  ultrasonic_echo_ranger #(.SAMPLES(SAMPLES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  ranger_state_t ranger;
  uer_cfg_t      regs;
  range_beat_t   status_due[$];
  drill_t        drills [DRILL_N];
  int            mismatch_count = 0;

  // stimulus shaping knobs
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   pressure_on = 1'b0;
  bit   typed_on = 1'b0;
  bit   drill_hold = 1'b0;
  logic [DIST_W-1:0] typed_dist;
  logic typed_to;
  int   sh_rise, sh_width, sh_k;

  // sequencer step helpers
  function automatic void enter_pulse();
    ranger.phase = PH_PULSE;
    ranger.count = '0;
  endfunction

  function automatic void enter_settle();
    if (regs.settle_ticks == 0) begin
      enter_pulse();
    end else begin
      ranger.phase = PH_SETTLE;
      ranger.count = '0;
    end
  endfunction

  // end of gap; high when the averaged distance is due
  function automatic logic finish_gap();
    if (ranger.rounds == ROUND_W'(SAMPLES % 64)) begin
      ranger.phase = PH_IDLE;
      ranger.count = '0;
      return 1'b1;
    end
    enter_settle();
    return 1'b0;
  endfunction

  function automatic logic close_round();
    logic [WSUM_W:0] s;
    s = {1'b0, ranger.wsum} + (WSUM_W + 1)'(ranger.width);
    ranger.wsum = s[WSUM_W] ? {WSUM_W{1'b1}} : s[WSUM_W-1:0];
    ranger.rounds = ranger.rounds + 1'b1;
    if (regs.gap_ticks == 0) return finish_gap();
    ranger.phase = PH_GAP;
    ranger.count = '0;
    return 1'b0;
  endfunction

  // one tick of the ranger: status beat for this input beat
  function automatic range_beat_t advance_ranger(logic start, logic echo);
    range_beat_t       r;
    logic [TICK_W-1:0] lim;
    logic              done;
    logic [PROD_W-1:0] quo;
    r = '0;
    done = 1'b0;
    r.trigger = (ranger.phase == PH_PULSE);
    r.busy_res = (ranger.phase != PH_IDLE);
    case (ranger.phase)
      PH_SETTLE: begin
        ranger.count++;
        if (ranger.count >= regs.settle_ticks) enter_pulse();
      end
      PH_PULSE: begin
        lim = (regs.pulse_ticks == 0) ? TICK_W'(1) : regs.pulse_ticks;
        ranger.count++;
        if (ranger.count >= lim) begin
          ranger.phase = PH_ECHO;
          ranger.count = '0;
          ranger.width = '0;
          ranger.seen = 1'b0;
        end
      end
      PH_ECHO: begin
        lim = (regs.timeout_ticks == 0) ? TICK_W'(1) : regs.timeout_ticks;
        ranger.count++;
        if (ranger.seen && !echo) begin
          // falling edge closes the round at once
          done = close_round();
        end else begin
          if (!ranger.seen) begin
            if (echo) begin
              ranger.seen = 1'b1;
              ranger.width = TICK_W'(1);
            end
          end else begin
            ranger.width = ranger.width + 1'b1;
          end
          if (ranger.count >= lim) begin
            if (!ranger.seen) begin
              ranger.width = '0;
              ranger.any_to = 1'b1;
            end
            done = close_round();
          end
        end
      end
      PH_GAP: begin
        ranger.count++;
        if (ranger.count >= regs.gap_ticks) done = finish_gap();
      end
      default: begin
        ranger.phase = PH_IDLE;
        if (start) begin
          ranger.rounds = '0;
          ranger.wsum = '0;
          ranger.any_to = 1'b0;
          ranger.width = '0;
          ranger.seen = 1'b0;
          enter_settle();
        end
      end
    endcase
    if (done) begin
      quo = (PROD_W'(ranger.wsum) * PROD_W'(regs.scale_q16)) / AVG_DIV;
      r.done_res = 1'b1;
      r.distance_q8 = (quo > PROD_W'(DIST_MAX)) ? DIST_MAX : quo[DIST_W-1:0];
      r.timed_out = ranger.any_to;
    end
    return r;
  endfunction

  function automatic uer_cfg_t small_cfg();
    uer_cfg_t c;
    c.settle_ticks  = TICK_W'($urandom_range(0, 3));
    c.pulse_ticks   = TICK_W'($urandom_range(0, 2));
    c.timeout_ticks = TICK_W'($urandom_range(0, 24));
    c.gap_ticks     = TICK_W'($urandom_range(0, 3));
    c.scale_q16     = SCALE_W'($urandom);
    return c;
  endfunction

  // register write, mirrored into the predictor at the same edge
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SETTLE:  regs.settle_ticks = val;
      CFG_PULSE:   regs.pulse_ticks = val;
      CFG_TIMEOUT: regs.timeout_ticks = val;
      CFG_GAP:     regs.gap_ticks = val;
      CFG_SCALE:   regs.scale_q16 = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input uer_cfg_t c);
    write_reg(CFG_SETTLE, c.settle_ticks);
    write_reg(CFG_PULSE, c.pulse_ticks);
    write_reg(CFG_TIMEOUT, c.timeout_ticks);
    write_reg(CFG_GAP, c.gap_ticks);
    write_reg(CFG_SCALE, c.scale_q16);
  endtask

  task automatic drain_status();
    while (status_due.size() != 0) @(posedge clk);
  endtask

  // feed tick beats; a drill stops on its distance beat
  task automatic pump(input int min_beats, input int want_dones, input int max_beats,
                      input bit drill);
    int          n, d, t, pick;
    bit          fin, took;
    logic        s, e;
    range_beat_t r;
    n = 0;
    d = 0;
    fin = 1'b0;
    sh_k = 0;
    while (!fin) begin
      @(posedge clk);
      took = in_chan.valid && in_chan.ready;
      if (took) begin
        r = advance_ranger(in_chan.start_req, in_chan.echo);
        if (r.done_res && drill && typed_on) begin
          r.distance_q8 = typed_dist;
          r.timed_out = typed_to;
        end
        status_due.push_back(r);
        n++;
        if (r.done_res) d++;
        fin = drill ? r.done_res : ((n >= min_beats && d >= want_dones) || n >= max_beats);
      end
      if (fin) begin
        in_chan.valid <= 1'b0;
      end else if (took || !in_chan.valid) begin
        if ($urandom_range(0, 99) < send_idle_pct) begin
          in_chan.valid <= 1'b0;
        end else begin
          // echo pulse shaped against the echo window of the round
          if (ranger.phase == PH_ECHO) begin
            if (sh_k == 0 && !drill) begin
              t = (regs.timeout_ticks == 0) ? 1 : int'(regs.timeout_ticks);
              pick = $urandom_range(0, 9);
              if (pick < 6) begin
                sh_rise = $urandom_range(0, 3);
                sh_width = $urandom_range(1, 8);
              end else if (pick < 8) begin
                sh_rise = $urandom_range(0, t + 2);
                sh_width = $urandom_range(1, t + 3);
              end else if (pick == 8) begin
                // no rise inside the window
                sh_rise = t + $urandom_range(0, 5);
                sh_width = $urandom_range(1, 4);
              end else begin
                // still high when the window closes
                sh_rise = $urandom_range(0, 2);
                sh_width = t + 5;
              end
            end
            e = (sh_k >= sh_rise) && (sh_k < sh_rise + sh_width);
            if (!drill && $urandom_range(0, 99) < 6) e = $urandom_range(0, 1);
            sh_k++;
          end else begin
            sh_k = 0;
            e = $urandom_range(0, 1);
          end
          if (drill) s = drill_hold || (ranger.phase == PH_IDLE);
          else if (ranger.phase == PH_IDLE) s = ($urandom_range(0, 99) < 40);
          else s = $urandom_range(0, 1);
          in_chan.valid <= 1'b1;
          in_chan.start_req <= s;
          in_chan.echo <= e;
        end
      end
    end
  endtask

  // result side: random stalls plus long hold-offs under pressure
  initial begin : receiver
    int hold_left, quiet_left;
    hold_left = 0;
    quiet_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else begin
        if (hold_left == 0 && pressure_on) begin
          if (quiet_left == 0) begin
            hold_left = 80;
            quiet_left = $urandom_range(150, 300);
          end else begin
            quiet_left--;
          end
        end
        if (hold_left != 0) begin
          hold_left--;
          out_chan.ready <= 1'b0;
        end else begin
          out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
      end
    end
  end

  // compare each result beat with the oldest expected status
  always @(posedge clk) begin : check_status
    range_beat_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (status_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat at %0t", $time);
      end else begin
        want = status_due.pop_front();
        if (out_chan.trigger !== want.trigger || out_chan.done_res !== want.done_res ||
            out_chan.distance_q8 !== want.distance_q8 ||
            out_chan.timed_out !== want.timed_out || out_chan.busy_res !== want.busy_res) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: expected trig %b done %b dist %0d tout %b busy %b, got trig %b done %b dist %0d tout %b busy %b",
                     $time, want.trigger, want.done_res, want.distance_q8, want.timed_out,
                     want.busy_res, out_chan.trigger, out_chan.done_res,
                     out_chan.distance_q8, out_chan.timed_out, out_chan.busy_res);
        end
      end
    end
  end

  // no beat on either channel for too long ends the run
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("** ultrasonic_echo_ranger: FAILED **");
    $finish;
  end

  initial begin
    uer_cfg_t cfg;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SETTLE;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.start_req = 1'b0;
    in_chan.echo = 1'b0;
    regs = '{SETTLE_RST, PULSE_RST, TIMEOUT_RST, GAP_RST, SCALE_RST};
    ranger = '0;
    ranger.phase = PH_IDLE;

    // settle, pulse, timeout, gap, scale | rise, width | hold start, typed, dist, timed out
    drills[0] = '{'{16'd4, 16'd2, 16'd30000, 16'd4, 16'd1124}, 17'd0, 17'd1,
                  1'b0, 1'b1, 24'd4, 1'b0};
    // no echo at all, one-tick window
    drills[1] = '{'{16'd0, 16'd1, 16'd1, 16'd0, 16'hFFFF}, 17'd70000, 17'd0,
                  1'b0, 1'b1, 24'd0, 1'b1};
    // zero pulse and timeout act as one tick; start held while busy
    drills[2] = '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF}, 17'd0, 17'd1,
                  1'b1, 1'b1, 24'd255, 1'b0};
    drills[3] = '{'{16'd3, 16'd2, 16'd100, 16'd2, 16'd0}, 17'd1, 17'd5,
                  1'b0, 1'b1, 24'd0, 1'b0};
    drills[4] = '{'{16'd0, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF}, 17'd0, 17'd20,
                  1'b0, 1'b0, 24'd0, 1'b0};
    // echo still high when the window closes
    drills[5] = '{'{16'd1, 16'd1, 16'd8, 16'd1, 16'd40000}, 17'd2, 17'd100,
                  1'b0, 1'b0, 24'd0, 1'b0};
    // echo rises on the last sample of the window
    drills[6] = '{'{16'd2, 16'd1, 16'd5, 16'd0, 16'd30000}, 17'd4, 17'd3,
                  1'b0, 1'b0, 24'd0, 1'b0};
    // echo rises only after the window
    drills[7] = '{'{16'd0, 16'd1, 16'd6, 16'd3, 16'hFFFF}, 17'd7, 17'd2,
                  1'b0, 1'b1, 24'd0, 1'b1};
    drills[8] = '{'{16'd4, 16'd1, 16'd12, 16'd0, 16'd12345}, 17'd0, 17'd12,
                  1'b0, 1'b0, 24'd0, 1'b0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed drills, one full measurement each
    for (int i = 0; i < DRILL_N; i++) begin
      drain_status();
      set_config(drills[i].cfg);
      typed_on = drills[i].typed;
      typed_dist = drills[i].exp_dist;
      typed_to = drills[i].tout;
      drill_hold = drills[i].hold_start;
      sh_rise = int'(drills[i].rise);
      sh_width = int'(drills[i].width);
      pump(0, 0, 0, 1'b1);
    end
    typed_on = 1'b0;
    drill_hold = 1'b0;

    // random phases over idling modes and settings
    for (int p = 0; p < 7; p++) begin
      drain_status();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      pressure_on = 1'b0;
      cfg = small_cfg();
      case (p)
        1: begin
          send_idle_pct = 55;
          cfg = '{16'd0, 16'd1, 16'd20, 16'd0, 16'hFFFF};
        end
        2: cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        3: recv_stall_pct = 55;
        4: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
        end
        5: pressure_on = 1'b1;
        default: ;
      endcase
      set_config(cfg);
      // longest settings: a short stretch inside the first settle phase
      if (p == 2) pump(150, 0, 150, 1'b0);
      else pump(60, 1, 250, 1'b0);
    end

    pressure_on = 1'b0;
    drain_status();
    repeat (20) @(posedge clk);
    if (status_due.size() != 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0d result beats never arrived", status_due.size());
    end
    if (mismatch_count == 0) begin
      $display("** ultrasonic_echo_ranger: PASSED **");
    end else begin
      $display("** ultrasonic_echo_ranger: FAILED **");
    end
    $finish;
  end

endmodule
